>>> src/dcd_pkg.sv
// ----------------------------------------------------------------------------
// Drive command decoder package
// Shared types, byte codes and duty helper functions for the decoder blocks.
// ----------------------------------------------------------------------------
package dcd_pkg;

   // Duty values on the bridge pins run from zero to this limit.
   localparam logic [6:0] DUTY_MAX = 7'd100;

   // Command and key byte codes.
   localparam logic [7:0] CH_STOP   = 8'h73;   // 's'
   localparam logic [7:0] CH_ANALOG = 8'h41;   // 'A'
   localparam logic [7:0] CH_DIGIT  = 8'h44;   // 'D'
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_1 = 8'h31;
   localparam logic [7:0] CH_2 = 8'h32;
   localparam logic [7:0] CH_3 = 8'h33;
   localparam logic [7:0] CH_4 = 8'h34;
   localparam logic [7:0] CH_5 = 8'h35;
   localparam logic [7:0] CH_6 = 8'h36;
   localparam logic [7:0] CH_7 = 8'h37;
   localparam logic [7:0] CH_8 = 8'h38;
   localparam logic [7:0] CH_9 = 8'h39;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_HIGH_DUTY    = 3'd0,
      CSR_LOW_DUTY     = 3'd1,
      CSR_QUARTER_TURN = 3'd2,
      CSR_HALF_TURN    = 3'd3,
      CSR_PASS         = 3'd4
   } csr_index_type;

   // Wheel direction codes; the unused code reads as stopped.
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   // Parser position inside a command packet.
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LEFT   = 2'd1,
      PH_RIGHT  = 2'd2,
      PH_DIGIT  = 2'd3
   } phase_type;

   // Classified command handed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_TICK,
      OP_STOP,
      OP_PREFIX,
      OP_KEY,
      OP_LEFT,
      OP_RIGHT,
      OP_DIGIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       apply;      // Parser is back at a header after this item.
   } cmd_type;

   // Pin duties of one wheel: index 0 forward, index 1 reverse.
   typedef logic [1:0][6:0] side_pins_type;
   // All four pins: left forward, left reverse, right forward, right reverse.
   typedef logic [3:0][6:0] pins_type;

   // One result transaction.
   typedef struct packed {
      pins_type pins;
      logic     maneuver_active;
      logic     halted;
   } rsp_type;

   function automatic logic [6:0] sat_duty(input logic [6:0] d);
      return (d > DUTY_MAX) ? DUTY_MAX : d;
   endfunction

   // Drive one wheel in a direction at a duty.
   function automatic side_pins_type drive(input dir_type dir, input logic [6:0] duty);
      side_pins_type s;
      s[0] = (dir == DIR_FWD) ? duty : 7'd0;
      s[1] = (dir == DIR_REV) ? duty : 7'd0;
      return s;
   endfunction

   // Turn a signed level into a wheel drive, clamped to the limit and to hi.
   function automatic side_pins_type drive_level(input logic [7:0] raw,
                                                 input logic [6:0] hi);
      logic [7:0] mag;
      logic [6:0] duty;
      dir_type    dir;
      if (raw[7]) begin
         mag = 8'd0 - raw;
         if (raw < 8'h9c) begin
            mag = {1'b0, DUTY_MAX};
         end
         dir = DIR_REV;
      end else begin
         mag = (raw > {1'b0, DUTY_MAX}) ? {1'b0, DUTY_MAX} : raw;
         dir = (raw == 8'd0) ? DIR_STOP : DIR_FWD;
      end
      duty = (mag[6:0] > hi) ? hi : mag[6:0];
      return drive(dir, duty);
   endfunction

endpackage

>>> src/dcd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Carries command bytes and millisecond ticks into the decoder.
// ----------------------------------------------------------------------------
interface dcd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ----------------------------------------------------------------------------
// Response channel interface
// Carries the four pin duties and the status flags out of the decoder.
// ----------------------------------------------------------------------------
interface dcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] left_fwd_duty;
   logic [6:0] left_rev_duty;
   logic [6:0] right_fwd_duty;
   logic [6:0] right_rev_duty;
   logic       maneuver_active;
   logic       halted;

   modport source (output valid, output left_fwd_duty, output left_rev_duty,
                   output right_fwd_duty, output right_rev_duty,
                   output maneuver_active, output halted, input ready);
   modport sink   (input valid, input left_fwd_duty, input left_rev_duty,
                   input right_fwd_duty, input right_rev_duty,
                   input maneuver_active, input halted, output ready);
endinterface

>>> src/dcd_front.sv
// ----------------------------------------------------------------------------
// Decoder front end
// Tracks the packet parser position and classifies each accepted transaction.
// ----------------------------------------------------------------------------
module dcd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             func,
   input  logic [7:0]       data_byte,
   output dcd_pkg::cmd_type cmd
);

   dcd_pkg::phase_type phase_ff, phase_in;
   dcd_pkg::op_type    op;

   // Classify the item against the current parser position.
   always_comb begin
      phase_in = phase_ff;
      op       = dcd_pkg::OP_TICK;
      if (!func) begin
         case (phase_ff)
            dcd_pkg::PH_HEADER: begin
               if (data_byte == dcd_pkg::CH_STOP) begin
                  op = dcd_pkg::OP_STOP;
               end else if (data_byte == dcd_pkg::CH_ANALOG) begin
                  op       = dcd_pkg::OP_PREFIX;
                  phase_in = dcd_pkg::PH_LEFT;
               end else if (data_byte == dcd_pkg::CH_DIGIT) begin
                  op       = dcd_pkg::OP_PREFIX;
                  phase_in = dcd_pkg::PH_DIGIT;
               end else begin
                  op = dcd_pkg::OP_KEY;
               end
            end
            dcd_pkg::PH_LEFT: begin
               op       = dcd_pkg::OP_LEFT;
               phase_in = dcd_pkg::PH_RIGHT;
            end
            dcd_pkg::PH_RIGHT: begin
               op       = dcd_pkg::OP_RIGHT;
               phase_in = dcd_pkg::PH_HEADER;
            end
            default: begin
               op       = dcd_pkg::OP_DIGIT;
               phase_in = dcd_pkg::PH_HEADER;
            end
         endcase
      end
      cmd.op        = op;
      cmd.data_byte = data_byte;
      cmd.apply     = (phase_in == dcd_pkg::PH_HEADER);
   end

   // Parser position is updated on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dcd_pkg::PH_HEADER;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

>>> src/dcd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the classifier from the executing back end.
// ----------------------------------------------------------------------------
module dcd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dcd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output dcd_pkg::cmd_type head_cmd
);

   dcd_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/dcd_back.sv
// ----------------------------------------------------------------------------
// Decoder back end
// Holds the drive state and registers, executes commands, and drives results.
// ----------------------------------------------------------------------------
module dcd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             cmd_valid,
   input  dcd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcd_pkg::rsp_type rsp_data
);

   // Configuration registers.
   logic [6:0]  high_duty_ff, low_duty_ff;
   logic [15:0] quarter_ff, half_ff, pass_ff;

   // Drive state.
   logic              halted_ff, halted_in;
   logic              timed_ff, timed_in;
   logic [15:0]       ticks_ff, ticks_in;
   dcd_pkg::dir_type  ldir_ff, ldir_in, rdir_ff, rdir_in;
   logic              analog_ff, analog_in;
   logic [7:0]        llev_ff, llev_in, rlev_ff, rlev_in;
   dcd_pkg::pins_type pins_ff, pins_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   dcd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [6:0] hi, lo;

   assign hi        = dcd_pkg::sat_duty(high_duty_ff);
   assign lo        = dcd_pkg::sat_duty(low_duty_ff);
   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_duty_ff <= 7'd90;
         low_duty_ff  <= 7'd0;
         quarter_ff   <= 16'd550;
         half_ff      <= 16'd1000;
         pass_ff      <= 16'd1500;
      end else if (csr_wr_en) begin
         case (csr_index)
            dcd_pkg::CSR_HIGH_DUTY:    high_duty_ff <= csr_wdata[6:0];
            dcd_pkg::CSR_LOW_DUTY:     low_duty_ff  <= csr_wdata[6:0];
            dcd_pkg::CSR_QUARTER_TURN: quarter_ff   <= csr_wdata;
            dcd_pkg::CSR_HALF_TURN:    half_ff      <= csr_wdata;
            dcd_pkg::CSR_PASS:         pass_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Execute one command and then run the apply step at a packet boundary.
   always_comb begin
      halted_in = halted_ff;
      timed_in  = timed_ff;
      ticks_in  = ticks_ff;
      ldir_in   = ldir_ff;
      rdir_in   = rdir_ff;
      analog_in = analog_ff;
      llev_in   = llev_ff;
      rlev_in   = rlev_ff;
      pins_in   = pins_ff;

      if (!halted_ff) begin
         case (cmd.op)
            dcd_pkg::OP_TICK: begin
               if (timed_ff && ticks_ff != 16'd0) begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
            dcd_pkg::OP_STOP: begin
               halted_in = 1'b1;
               timed_in  = 1'b0;
               pins_in   = '0;
            end
            dcd_pkg::OP_KEY: begin
               analog_in = 1'b0;
               case (cmd.data_byte)
                  dcd_pkg::CH_7: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_FWD, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_REV, lo)};
                  dcd_pkg::CH_8: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_FWD, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_FWD, hi)};
                  dcd_pkg::CH_9: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_REV, lo),
                                            dcd_pkg::drive(dcd_pkg::DIR_FWD, hi)};
                  dcd_pkg::CH_4: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_FWD, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_REV, hi)};
                  dcd_pkg::CH_6: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_REV, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_FWD, hi)};
                  dcd_pkg::CH_1: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_REV, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_REV, lo)};
                  dcd_pkg::CH_2: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_REV, hi),
                                            dcd_pkg::drive(dcd_pkg::DIR_REV, hi)};
                  dcd_pkg::CH_3: pins_in = {dcd_pkg::drive(dcd_pkg::DIR_REV, lo),
                                            dcd_pkg::drive(dcd_pkg::DIR_REV, hi)};
                  default: ;
               endcase
            end
            dcd_pkg::OP_LEFT: begin
               llev_in = cmd.data_byte;
            end
            dcd_pkg::OP_RIGHT: begin
               rlev_in   = cmd.data_byte;
               analog_in = 1'b1;
            end
            dcd_pkg::OP_DIGIT: begin
               case (cmd.data_byte) inside
                  dcd_pkg::CH_0, dcd_pkg::CH_1: begin
                     timed_in = 1'b0;
                     pins_in  = '0;
                  end
                  dcd_pkg::CH_4, dcd_pkg::CH_5: begin
                     pins_in  = '0;
                     timed_in = 1'b1;
                     ldir_in  = dcd_pkg::DIR_FWD;
                     rdir_in  = dcd_pkg::DIR_FWD;
                     ticks_in = pass_ff;
                  end
                  dcd_pkg::CH_6, dcd_pkg::CH_7: begin
                     pins_in  = '0;
                     timed_in = 1'b1;
                     ldir_in  = dcd_pkg::DIR_REV;
                     rdir_in  = dcd_pkg::DIR_FWD;
                     ticks_in = quarter_ff;
                  end
                  dcd_pkg::CH_8, dcd_pkg::CH_9: begin
                     pins_in  = '0;
                     timed_in = 1'b1;
                     ldir_in  = dcd_pkg::DIR_FWD;
                     rdir_in  = dcd_pkg::DIR_REV;
                     ticks_in = quarter_ff;
                  end
                  dcd_pkg::CH_2: begin
                     pins_in  = '0;
                     timed_in = 1'b1;
                     ldir_in  = dcd_pkg::DIR_REV;
                     rdir_in  = dcd_pkg::DIR_FWD;
                     ticks_in = half_ff;
                  end
                  dcd_pkg::CH_3: begin
                     pins_in  = '0;
                     timed_in = 1'b1;
                     ldir_in  = dcd_pkg::DIR_FWD;
                     rdir_in  = dcd_pkg::DIR_REV;
                     ticks_in = half_ff;
                  end
                  default: analog_in = 1'b0;
               endcase
            end
            default: ;
         endcase

         // Apply step: an expired maneuver ends, a running one wins,
         // otherwise analog mode drives the stored levels.
         if (!halted_in && cmd.apply) begin
            if (timed_in && ticks_in == 16'd0) begin
               timed_in = 1'b0;
               pins_in  = '0;
            end
            if (timed_in) begin
               pins_in = {dcd_pkg::drive(rdir_in, hi), dcd_pkg::drive(ldir_in, hi)};
            end else if (analog_in) begin
               pins_in = {dcd_pkg::drive_level(rlev_in, hi),
                          dcd_pkg::drive_level(llev_in, hi)};
            end
         end
      end

      rsp_data_in.pins            = pins_in;
      rsp_data_in.maneuver_active = timed_in;
      rsp_data_in.halted          = halted_in;
      rsp_valid_in = cmd_pop || (rsp_valid_ff && !rsp_ready);
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff    <= 1'b0;
         timed_ff     <= 1'b0;
         ticks_ff     <= 16'd0;
         ldir_ff      <= dcd_pkg::DIR_STOP;
         rdir_ff      <= dcd_pkg::DIR_STOP;
         analog_ff    <= 1'b0;
         llev_ff      <= 8'd0;
         rlev_ff      <= 8'd0;
         pins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            halted_ff <= halted_in;
            timed_ff  <= timed_in;
            ticks_ff  <= ticks_in;
            ldir_ff   <= ldir_in;
            rdir_ff   <= rdir_in;
            analog_ff <= analog_in;
            llev_ff   <= llev_in;
            rlev_ff   <= rlev_in;
            pins_ff   <= pins_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> src/drive_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// Drive command decoder
// Turns command bytes and millisecond ticks into H-bridge duties for two wheels.
// ----------------------------------------------------------------------------
// The request channel takes one transaction per item: func low with a command
// byte in data_byte, or func high for a one millisecond tick. For each request
// the response channel returns exactly one transaction with the four pin
// duties, the maneuver flag and the halted flag, in request order.
// The front end classifies each byte against the packet parser position and
// writes it into a two-entry queue; the back end executes one queued command
// per cycle into an output register, unless a held result is not yet taken.
// Each result passes through a queue entry and then the output register; the
// block sustains one transaction per cycle while the receiver keeps ready high.
// When the receiver stalls, the output register holds its result and the queue
// keeps accepting until it is full, so up to three transactions wait inside.
// Configuration writes on csr_wr_en take effect at once; the user makes them
// only while the block is idle, which it does not enforce. Reset is synchronous
// and restores register defaults, stops both wheels, clears halted and the queue.
// ----------------------------------------------------------------------------
module drive_command_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   dcd_req_if.sink     req_ch,
   dcd_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic             req_accept;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;
   dcd_pkg::cmd_type front_cmd;
   dcd_pkg::cmd_type head_cmd;
   dcd_pkg::rsp_type rsp_data;

   assign req_ch.ready = !q_full;
   assign req_accept   = req_ch.valid && !q_full;

   // Front end: parser position and classification.
   dcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .func      (req_ch.func),
      .data_byte (req_ch.data_byte),
      .cmd       (front_cmd)
   );

   // Queue between classification and execution.
   dcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // Back end: drive state, registers and result output.
   dcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_ch.left_fwd_duty   = rsp_data.pins[0];
   assign rsp_ch.left_rev_duty   = rsp_data.pins[1];
   assign rsp_ch.right_fwd_duty  = rsp_data.pins[2];
   assign rsp_ch.right_rev_duty  = rsp_data.pins[3];
   assign rsp_ch.maneuver_active = rsp_data.maneuver_active;
   assign rsp_ch.halted          = rsp_data.halted;

endmodule

>>> verif/drive_command_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command decoder testbench
// Drives command bytes and millisecond ticks into the decoder under random
// idling on both channels. A scoreboard predicts the four pin duties and the
// status flags for every accepted request and checks each result in order.
// ----------------------------------------------------------------------------
module drive_command_decoder_unit_tb;

   localparam int LEFT_SIDE   = 0;
   localparam int RIGHT_SIDE  = 1;
   localparam int QUIET_LIMIT = 2000;

   // One result transaction as the scoreboard sees it.
   typedef struct packed {
      logic [6:0] left_fwd;
      logic [6:0] left_rev;
      logic [6:0] right_fwd;
      logic [6:0] right_rev;
      logic       active;
      logic       halted;
   } duty_set_type;

   // Tracks the decoder state, predicts the duties of each transaction and
   // compares them with what comes out.
   class duty_scoreboard;
      logic [6:0]         high_duty, low_duty;
      logic [15:0]        quarter_ticks, half_ticks, pass_ticks;
      dcd_pkg::phase_type parse_at;
      logic               analog_on;
      logic [7:0]         left_level, right_level;
      logic               maneuver_on;
      logic [15:0]        ticks_left;
      dcd_pkg::dir_type   maneuver_left, maneuver_right;
      logic [6:0]         duty [4];
      logic               halted;
      duty_set_type       pending_duties [$];
      int                 commands, results, errors;

      function new();
         high_duty      = 7'd90;
         low_duty       = 7'd0;
         quarter_ticks  = 16'd550;
         half_ticks     = 16'd1000;
         pass_ticks     = 16'd1500;
         parse_at       = dcd_pkg::PH_HEADER;
         analog_on      = 1'b0;
         left_level     = 8'd0;
         right_level    = 8'd0;
         maneuver_on    = 1'b0;
         ticks_left     = 16'd0;
         maneuver_left  = dcd_pkg::DIR_STOP;
         maneuver_right = dcd_pkg::DIR_STOP;
         halted         = 1'b0;
         foreach (duty[i]) duty[i] = 7'd0;
      endfunction

      function void set_register(dcd_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            dcd_pkg::CSR_HIGH_DUTY:    high_duty = value[6:0];
            dcd_pkg::CSR_LOW_DUTY:     low_duty = value[6:0];
            dcd_pkg::CSR_QUARTER_TURN: quarter_ticks = value;
            dcd_pkg::CSR_HALF_TURN:    half_ticks = value;
            dcd_pkg::CSR_PASS:         pass_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_duties.size();
      endfunction

      // Register values above full scale act as full scale.
      function logic [6:0] limit_duty(logic [6:0] d);
         return (d > dcd_pkg::DUTY_MAX) ? dcd_pkg::DUTY_MAX : d;
      endfunction

      function void set_side(int side, dcd_pkg::dir_type dir, logic [6:0] d);
         duty[side * 2]     = (dir == dcd_pkg::DIR_FWD) ? d : 7'd0;
         duty[side * 2 + 1] = (dir == dcd_pkg::DIR_REV) ? d : 7'd0;
      endfunction

      function void clear_pins();
         foreach (duty[i]) duty[i] = 7'd0;
      endfunction

      // A signed level is clamped to full scale, then capped at the high duty.
      function void level_side(int side, logic [7:0] raw);
         int               v, mag, full, cap;
         dcd_pkg::dir_type dir;
         v    = int'($signed(raw));
         full = int'(dcd_pkg::DUTY_MAX);
         cap  = int'(limit_duty(high_duty));
         if (v > full) v = full;
         if (v < -full) v = -full;
         mag = (v < 0) ? -v : v;
         if (mag > cap) mag = cap;
         dir = (v > 0) ? dcd_pkg::DIR_FWD : ((v < 0) ? dcd_pkg::DIR_REV : dcd_pkg::DIR_STOP);
         set_side(side, dir, 7'(mag));
      endfunction

      // One-shot keypad pattern; arc turns run the inner wheel at low duty.
      function void play_key(logic [7:0] b);
         logic [6:0] hi, lo;
         hi = limit_duty(high_duty);
         lo = limit_duty(low_duty);
         case (b)
            dcd_pkg::CH_7: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_REV, lo);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_FWD, hi);
            end
            dcd_pkg::CH_8: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_FWD, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_FWD, hi);
            end
            dcd_pkg::CH_9: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_FWD, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_REV, lo);
            end
            dcd_pkg::CH_4: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_REV, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_FWD, hi);
            end
            dcd_pkg::CH_6: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_FWD, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_REV, hi);
            end
            dcd_pkg::CH_1: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_REV, lo);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_REV, hi);
            end
            dcd_pkg::CH_2: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_REV, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_REV, hi);
            end
            dcd_pkg::CH_3: begin
               set_side(LEFT_SIDE, dcd_pkg::DIR_REV, hi);
               set_side(RIGHT_SIDE, dcd_pkg::DIR_REV, lo);
            end
            default: ;
         endcase
         analog_on = 1'b0;
      endfunction

      function void start_maneuver(dcd_pkg::dir_type l, dcd_pkg::dir_type r,
                                   logic [15:0] n);
         clear_pins();
         maneuver_on    = 1'b1;
         maneuver_left  = l;
         maneuver_right = r;
         ticks_left     = n;
      endfunction

      function void run_digit(logic [7:0] b);
         case (b)
            dcd_pkg::CH_0, dcd_pkg::CH_1: begin
               maneuver_on = 1'b0;
               clear_pins();
            end
            dcd_pkg::CH_4, dcd_pkg::CH_5:
               start_maneuver(dcd_pkg::DIR_FWD, dcd_pkg::DIR_FWD, pass_ticks);
            dcd_pkg::CH_6, dcd_pkg::CH_7:
               start_maneuver(dcd_pkg::DIR_REV, dcd_pkg::DIR_FWD, quarter_ticks);
            dcd_pkg::CH_8, dcd_pkg::CH_9:
               start_maneuver(dcd_pkg::DIR_FWD, dcd_pkg::DIR_REV, quarter_ticks);
            dcd_pkg::CH_2:
               start_maneuver(dcd_pkg::DIR_REV, dcd_pkg::DIR_FWD, half_ticks);
            dcd_pkg::CH_3:
               start_maneuver(dcd_pkg::DIR_FWD, dcd_pkg::DIR_REV, half_ticks);
            default:
               analog_on = 1'b0;
         endcase
      endfunction

      // Runs once the parser is back at a header: a live maneuver wins, an
      // expired one clears the pins, and analog mode follows the levels.
      function void settle_pins();
         if (maneuver_on) begin
            if (ticks_left == 16'd0) begin
               maneuver_on = 1'b0;
               clear_pins();
            end else begin
               set_side(LEFT_SIDE, maneuver_left, limit_duty(high_duty));
               set_side(RIGHT_SIDE, maneuver_right, limit_duty(high_duty));
               return;
            end
         end
         if (analog_on) begin
            level_side(LEFT_SIDE, left_level);
            level_side(RIGHT_SIDE, right_level);
         end
      endfunction

      // Notes an accepted request transaction and queues the duties it gives.
      function void note_command(logic is_tick, logic [7:0] b);
         duty_set_type want;
         commands++;
         if (!halted) begin
            if (is_tick) begin
               if (maneuver_on && ticks_left != 16'd0) ticks_left--;
            end else begin
               case (parse_at)
                  dcd_pkg::PH_HEADER: begin
                     if (b == dcd_pkg::CH_STOP) begin
                        halted      = 1'b1;
                        maneuver_on = 1'b0;
                        clear_pins();
                     end else if (b == dcd_pkg::CH_ANALOG) begin
                        parse_at = dcd_pkg::PH_LEFT;
                     end else if (b == dcd_pkg::CH_DIGIT) begin
                        parse_at = dcd_pkg::PH_DIGIT;
                     end else begin
                        play_key(b);
                     end
                  end
                  dcd_pkg::PH_LEFT: begin
                     left_level = b;
                     parse_at   = dcd_pkg::PH_RIGHT;
                  end
                  dcd_pkg::PH_RIGHT: begin
                     right_level = b;
                     analog_on   = 1'b1;
                     parse_at    = dcd_pkg::PH_HEADER;
                  end
                  default: begin
                     run_digit(b);
                     parse_at = dcd_pkg::PH_HEADER;
                  end
               endcase
            end
            if (!halted && parse_at == dcd_pkg::PH_HEADER) settle_pins();
         end
         want.left_fwd  = duty[0];
         want.left_rev  = duty[1];
         want.right_fwd = duty[2];
         want.right_rev = duty[3];
         want.active    = maneuver_on;
         want.halted    = halted;
         pending_duties.push_back(want);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // Checks a result transaction against the oldest prediction.
      function void check_duties(duty_set_type got);
         duty_set_type want;
         if (pending_duties.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual %h", $time, got);
            return;
         end
         want = pending_duties.pop_front();
         results++;
         compare_field("left_fwd_duty", want.left_fwd, got.left_fwd);
         compare_field("left_rev_duty", want.left_rev, got.left_rev);
         compare_field("right_fwd_duty", want.right_fwd, got.right_fwd);
         compare_field("right_rev_duty", want.right_rev, got.right_rev);
         compare_field("maneuver_active", want.active, got.active);
         compare_field("halted", want.halted, got.halted);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   dcd_pkg::csr_index_type csr_index;
   logic [15:0]            csr_wdata;
   bit                     idle_on;
   int                     send_calm;
   int                     settings;
   duty_set_type           seen_duties;
   duty_scoreboard         sb;

   dcd_req_if req_ch ();
   dcd_rsp_if rsp_ch ();

   drive_command_decoder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall bursts alternate with stretches of steady ready.
   initial begin
      int stall, calm;
      rsp_ch.ready = 1'b0;
      stall = 0;
      calm  = 0;
      forever begin
         @(negedge clock);
         if (stall == 0 && calm == 0) begin
            if (idle_on && $urandom_range(0, 1) == 1) stall = $urandom_range(1, 16);
            else calm = $urandom_range(1, 40);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            calm--;
         end
      end
   end

   // Every result transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_duties.left_fwd  = rsp_ch.left_fwd_duty;
         seen_duties.left_rev  = rsp_ch.left_rev_duty;
         seen_duties.right_fwd = rsp_ch.right_fwd_duty;
         seen_duties.right_rev = rsp_ch.right_rev_duty;
         seen_duties.active    = rsp_ch.maneuver_active;
         seen_duties.halted    = rsp_ch.halted;
         sb.check_duties(seen_duties);
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL drive_command_decoder_unit");
      $finish;
   end

   // Offers one request transaction, with an occasional gap before it.
   task automatic send_item(input logic is_tick, input logic [7:0] b);
      if (idle_on && send_calm == 0) begin
         send_calm = $urandom_range(1, 30);
         if ($urandom_range(0, 1) == 1) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end else if (send_calm > 0) begin
         send_calm--;
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= is_tick;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_command(is_tick, b);
      @(negedge clock);
   endtask

   // The data byte of a tick is ignored, so it carries noise.
   task automatic send_tick();
      send_item(1'b1, 8'($urandom));
   endtask

   task automatic maybe_tick();
      if ($urandom_range(0, 4) == 0) send_tick();
   endtask

   // Holds the sender until every predicted result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_register(input dcd_pkg::csr_index_type idx,
                                 input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_register(idx, value);
      @(negedge clock);
   endtask

   // New register setting, written only once the block has gone idle.
   task automatic apply_setting(input logic [6:0] hi, input logic [6:0] lo,
                                input logic [15:0] quarter, input logic [15:0] half,
                                input logic [15:0] pass);
      wait_drained();
      write_register(dcd_pkg::CSR_HIGH_DUTY, {9'd0, hi});
      write_register(dcd_pkg::CSR_LOW_DUTY, {9'd0, lo});
      write_register(dcd_pkg::CSR_QUARTER_TURN, quarter);
      write_register(dcd_pkg::CSR_HALF_TURN, half);
      write_register(dcd_pkg::CSR_PASS, pass);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      settings++;
   endtask

   // Levels lean toward the clamp and sign boundaries.
   function automatic logic [7:0] pick_level();
      logic [7:0] corner_levels [9] = '{8'h00, 8'h01, 8'h64, 8'h65, 8'h7f,
                                        8'h80, 8'h9b, 8'h9c, 8'hff};
      if ($urandom_range(0, 2) == 0) return corner_levels[$urandom_range(0, 8)];
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_digit();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return dcd_pkg::CH_0 + 8'($urandom_range(0, 9));
   endfunction

   // Header bytes other than the stop and packet prefixes.
   function automatic logic [7:0] pick_key();
      logic [7:0] b;
      if ($urandom_range(0, 3) != 0) return dcd_pkg::CH_0 + 8'($urandom_range(0, 9));
      do b = 8'($urandom);
      while (b == dcd_pkg::CH_STOP || b == dcd_pkg::CH_ANALOG || b == dcd_pkg::CH_DIGIT);
      return b;
   endfunction

   // Whole packets with random content, mixed with tick runs, ticks
   // inside packets, invalid digits and stray key bytes.
   task automatic run_random(input int n);
      int stop_at, k;
      stop_at = sb.commands + n;
      while (sb.commands < stop_at) begin
         k = $urandom_range(0, 99);
         if (k < 2) begin
            wait_drained();
         end else if (k < 30) begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
               send_tick();
         end else if (k < 55) begin
            send_item(1'b0, dcd_pkg::CH_ANALOG);
            maybe_tick();
            send_item(1'b0, pick_level());
            maybe_tick();
            send_item(1'b0, pick_level());
         end else if (k < 75) begin
            send_item(1'b0, dcd_pkg::CH_DIGIT);
            maybe_tick();
            send_item(1'b0, pick_digit());
         end else begin
            send_item(1'b0, pick_key());
         end
      end
   endtask

   // Main sequence: reset, directed items, random phases, stop at the end.
   initial begin
      int i;
      sb               = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = dcd_pkg::CSR_HIGH_DUTY;
      csr_wdata        = 16'd0;
      req_ch.valid     = 1'b0;
      req_ch.func      = 1'b0;
      req_ch.data_byte = 8'd0;
      idle_on          = 1'b1;
      send_calm        = 0;
      settings         = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every key, including the ones that leave the pins alone.
      send_item(1'b0, dcd_pkg::CH_1);
      send_item(1'b0, dcd_pkg::CH_2);
      send_item(1'b0, dcd_pkg::CH_3);
      send_item(1'b0, dcd_pkg::CH_4);
      send_item(1'b0, dcd_pkg::CH_6);
      send_item(1'b0, dcd_pkg::CH_7);
      send_item(1'b0, dcd_pkg::CH_8);
      send_item(1'b0, dcd_pkg::CH_9);
      send_item(1'b0, dcd_pkg::CH_0);
      send_item(1'b0, dcd_pkg::CH_5);
      send_item(1'b0, 8'hff);
      // Levels at both clamps, including the most negative byte.
      send_item(1'b0, dcd_pkg::CH_ANALOG);
      send_item(1'b0, 8'h7f);
      send_item(1'b0, 8'h80);
      // A packet split by ticks holds the pins until it completes.
      send_item(1'b0, dcd_pkg::CH_ANALOG);
      send_tick();
      send_item(1'b0, 8'h64);
      send_item(1'b0, 8'h9c);
      // An invalid digit drops analog mode.
      send_item(1'b0, dcd_pkg::CH_DIGIT);
      send_item(1'b0, 8'h00);
      // Start a forward pass, tick once, then cancel it.
      send_item(1'b0, dcd_pkg::CH_DIGIT);
      send_item(1'b0, dcd_pkg::CH_4);
      send_tick();
      send_item(1'b0, dcd_pkg::CH_DIGIT);
      send_item(1'b0, dcd_pkg::CH_0);
      run_random(200);

      // Fixed settings at the extremes, then random ones with short maneuvers.
      apply_setting(7'd100, 7'd0, 16'd3, 16'd6, 16'd10);
      run_random(215);
      apply_setting(7'd0, 7'd100, 16'd0, 16'd0, 16'd0);
      run_random(215);
      apply_setting(7'd127, 7'd127, 16'hffff, 16'hffff, 16'hffff);
      run_random(215);
      for (i = 0; i < 4; i++) begin
         if (i == 3) idle_on = 1'b0;
         apply_setting(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                       16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)),
                       16'($urandom_range(0, 40)));
         run_random(215);
      end

      // Stop halts the block for good; everything after it is ignored.
      send_item(1'b0, dcd_pkg::CH_STOP);
      send_tick();
      send_item(1'b0, dcd_pkg::CH_ANALOG);
      send_item(1'b0, 8'h7f);
      send_item(1'b0, 8'h7f);
      send_item(1'b0, dcd_pkg::CH_DIGIT);
      send_item(1'b0, dcd_pkg::CH_4);
      send_item(1'b0, dcd_pkg::CH_8);
      send_item(1'b0, dcd_pkg::CH_STOP);
      send_tick();

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Ran %0d commands and ticks over %0d register settings; %0d results checked.",
               sb.commands, settings, sb.results);
      $display("Covered keys, analog packets, timed maneuvers, invalid digits and the stop.");
      if (sb.errors == 0) begin
         $display("PASS drive_command_decoder_unit");
      end else begin
         $display("FAIL drive_command_decoder_unit");
      end
      $finish;
   end

endmodule

>>> sim.f
src/dcd_pkg.sv
src/dcd_req_if.sv
src/dcd_front.sv
src/dcd_queue.sv
src/dcd_back.sv
src/drive_command_decoder_unit.sv
verif/drive_command_decoder_unit_tb.sv
